>>> hdl/ses_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ses_pkg
// Shared constants and types for the sparse entry store: sizes of the entry
// memory, field widths, operation codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package ses_pkg;

  // Number of entries the store can hold, and coordinate width.
  localparam int CAPACITY   = 256;
  localparam int INDEX_BITS = 16;
  localparam int VALUE_BITS = 32;
  localparam int REG_BITS   = 17;

  localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(CAPACITY);

  // Register reset values: every index in range.
  localparam logic [REG_BITS-1:0] ROW_COUNT_RESET = REG_BITS'(65536);
  localparam logic [REG_BITS-1:0] COL_COUNT_RESET = REG_BITS'(65536);

  // Operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // One stored entry.
  typedef struct packed {
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

endpackage : ses_pkg
`default_nettype wire

>>> hdl/sparse_entry_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_entry_store
// Keyed store of sparse matrix entries in coordinate form. A request either
// reads the value stored at a (row, column) pair or writes one, appending a
// new entry when the pair is not yet present.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  -------   -------------------   ---------------------------------------
//  in        in_valid / in_ready   opcode, row_index, col_index, write_value
//  out       out_valid / out_ready read_value, found, status
//  cfg       cfg_write (no wait)   cfg_index, cfg_data
//
// An out-of-range request goes straight to the result state; otherwise the
// entries are read from the single entry memory one per cycle through its
// read port, and the scan stops at the first coordinate match.
// Reset clears the entry count and the state machine; the entry memory is not
// cleared, since only entries below the count are ever read.
// A stalled output holds the store in its final state until the result is
// taken; a new request is taken once the previous result has been registered.
//
module sparse_entry_store
  import ses_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         opcode,
  input  wire logic [INDEX_BITS-1:0]        row_index,
  input  wire logic [INDEX_BITS-1:0]        col_index,
  input  wire logic signed [VALUE_BITS-1:0] write_value,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [VALUE_BITS-1:0]      read_value,
  output logic                              found,
  output logic [1:0]                        status,
  // configuration port
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [REG_BITS-1:0]          cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [REG_BITS-1:0] row_count;
  logic [REG_BITS-1:0] col_count;

  // Number of valid entries, 0 to CAPACITY.
  logic [COUNT_BITS-1:0] entry_count;

  // The request being served.
  logic                  req_op;
  logic [INDEX_BITS-1:0] req_row;
  logic [INDEX_BITS-1:0] req_col;
  logic [VALUE_BITS-1:0] req_value;
  logic                  req_range_err;

  // Scan state: next entry to read, and the read that is in flight.
  logic [COUNT_BITS-1:0] issue_idx;
  logic                  rd_vld;
  logic [ADDR_BITS-1:0]  rd_idx;

  // Outcome of the scan.
  logic                  hit;
  logic [ADDR_BITS-1:0]  hit_slot;
  logic [VALUE_BITS-1:0] hit_value;

  // Entry memory with a registered read port and one write port.
  entry_t                mem [CAPACITY];
  entry_t                mem_rdata;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  entry_t                mem_wdata;

  logic in_fire;
  logic result_fire;
  logic rd_match;
  logic issue_more;
  logic range_err;
  logic append_ok;

  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign result_fire = (state == S_DONE) && (!out_valid || out_ready);

  // Row and column limits are 17 bits wide so that the full index range fits.
  assign range_err = ({1'b0, row_index} >= row_count) || ({1'b0, col_index} >= col_count);

  assign rd_match   = rd_vld && (mem_rdata.row == req_row) && (mem_rdata.col == req_col);
  assign issue_more = (issue_idx < entry_count);
  assign append_ok  = (entry_count != COUNT_FULL);

  // The memory is read every cycle at the scan pointer; the data only counts
  // when a read was issued in the cycle before.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[issue_idx[ADDR_BITS-1:0]];
  end

  // Write back at the end of a set: an overwrite of the matching slot, or an
  // append at the first free slot. Writes happen only once the scan is over,
  // so no read of the same request can see a stale entry.
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = entry_count[ADDR_BITS-1:0];
    mem_wdata.row = req_row;
    mem_wdata.col = req_col;
    mem_wdata.value = req_value;
    if (result_fire && !req_range_err && (req_op == OP_SET)) begin
      if (hit) begin
        mem_we    = 1'b1;
        mem_waddr = hit_slot;
      end else if (append_ok) begin
        mem_we = 1'b1;
      end
    end
  end

  // Configuration writes are taken at any time.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RESET;
      col_count <= COL_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Main state machine with its registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      issue_idx   <= '0;
      rd_vld      <= 1'b0;
      hit         <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new one is registered keeps
      // the output valid.
      if (out_valid && out_ready && !result_fire) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_op        <= opcode;
            req_row       <= row_index;
            req_col       <= col_index;
            req_value     <= write_value;
            req_range_err <= range_err;
            issue_idx     <= '0;
            rd_vld        <= 1'b0;
            hit           <= 1'b0;
            // An out-of-range request leaves the store untouched.
            state         <= range_err ? S_DONE : S_SCAN;
          end
        end

        S_SCAN: begin
          if (rd_match) begin
            hit       <= 1'b1;
            hit_slot  <= rd_idx;
            hit_value <= mem_rdata.value;
            rd_vld    <= 1'b0;
            state     <= S_DONE;
          end else if (issue_more) begin
            rd_vld    <= 1'b1;
            rd_idx    <= issue_idx[ADDR_BITS-1:0];
            issue_idx <= issue_idx + COUNT_BITS'(1);
          end else begin
            // All entries issued; finish once the last read has been checked.
            rd_vld <= 1'b0;
            if (!rd_vld) begin
              state <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (result_fire) begin
            out_valid <= 1'b1;
            if (req_range_err) begin
              read_value <= '0;
              found      <= 1'b0;
              status     <= ST_RANGE;
            end else if (hit) begin
              found      <= 1'b1;
              status     <= ST_OK;
              read_value <= (req_op == OP_GET) ? hit_value : '0;
            end else begin
              read_value <= '0;
              found      <= 1'b0;
              if ((req_op == OP_SET) && !append_ok) begin
                status <= ST_FULL;
              end else begin
                status <= ST_OK;
              end
              if ((req_op == OP_SET) && append_ok) begin
                entry_count <= entry_count + COUNT_BITS'(1);
              end
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A match is only ever reported with an ok status.
  a_found_ok : assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == ST_OK))
    else $error("found reported with a non-ok status");

  // A non-zero read value can only come from a matching entry.
  a_value_found : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (read_value != '0)) |-> found)
    else $error("non-zero read value without a match");

  // The entry count never exceeds the capacity of the memory.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_FULL)
    else $error("entry count beyond capacity");

  // One request at a time: no request is taken in the cycle after another.
  a_one_at_time : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in progress");
`endif

endmodule : sparse_entry_store
`default_nettype wire
